// ===== hw/rtl/uartrx_pkg.sv =====
// Shared types and constants for the filtered UART byte receiver.
package uartrx_pkg;

	// Result status codes.
	localparam logic [1:0] STATUS_NONE     = 2'd0;
	localparam logic [1:0] STATUS_ACCEPTED = 2'd1;
	localparam logic [1:0] STATUS_FRAMING  = 2'd2;
	localparam logic [1:0] STATUS_FILTERED = 2'd3;

	// Frame format and filter.
	localparam int unsigned DATA_BITS   = 8;
	localparam logic [7:0]  FILTER_BYTE = 8'h7F;
	localparam logic [7:0]  ZERO_BYTE   = 8'h00;

	// Configuration register map.
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_DATA_W  = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_START_WAIT     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_SPACING = 1'd1;
	localparam logic [15:0] START_WAIT_RESET     = 16'd105;
	localparam logic [15:0] SAMPLE_SPACING_RESET = 16'd105;

	// One configuration write beat.
	typedef struct packed {
		logic                  wr;
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_wr_t;

	// One result item.
	typedef struct packed {
		logic [1:0] status;
		logic [7:0] rx_byte;
	} result_t;

endpackage

// ===== hw/rtl/uartrx_frame.sv =====
// Frame tracker: tick counter, bit position, shift register and stop check.
module uartrx_frame (
	input  logic               clk,
	input  logic               arst_n,
	input  uartrx_pkg::cfg_wr_t cfg,
	input  logic               step,
	input  logic               rx_level,
	output uartrx_pkg::result_t result
);
	import uartrx_pkg::*;

	logic [15:0] start_wait_q;
	logic [15:0] sample_spacing_q;
	logic        last_level_q;
	logic        receiving_q;
	logic [15:0] tick_left_q;
	logic [3:0]  bit_position_q;
	logic [7:0]  shift_value_q;

	logic        receiving_d;
	logic [15:0] tick_left_d;
	logic [3:0]  bit_position_d;
	logic [7:0]  shift_value_d;

	// Next state and result for the current tick.
	always_comb begin
		receiving_d    = receiving_q;
		tick_left_d    = tick_left_q;
		bit_position_d = bit_position_q;
		shift_value_d  = shift_value_q;
		result.status  = STATUS_NONE;
		result.rx_byte = ZERO_BYTE;
		if (!receiving_q) begin
			if (last_level_q && !rx_level) begin
				receiving_d    = 1'b1;
				tick_left_d    = start_wait_q;
				bit_position_d = 4'd0;
				shift_value_d  = ZERO_BYTE;
			end
		end else if (tick_left_q > 16'd1) begin
			tick_left_d = tick_left_q - 16'd1;
		end else if (bit_position_q < 4'(DATA_BITS)) begin
			shift_value_d[bit_position_q[2:0]] = rx_level;
			bit_position_d = bit_position_q + 4'd1;
			tick_left_d    = sample_spacing_q;
		end else begin
			result.rx_byte = shift_value_q;
			if (!rx_level) begin
				result.status = STATUS_FRAMING;
			end else if (shift_value_q == ZERO_BYTE || shift_value_q == FILTER_BYTE) begin
				result.status = STATUS_FILTERED;
			end else begin
				result.status = STATUS_ACCEPTED;
			end
			receiving_d    = 1'b0;
			tick_left_d    = 16'd0;
			bit_position_d = 4'd0;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_wait_q     <= START_WAIT_RESET;
			sample_spacing_q <= SAMPLE_SPACING_RESET;
		end else if (cfg.wr) begin
			case (cfg.index)
				CFG_START_WAIT:     start_wait_q     <= cfg.data;
				CFG_SAMPLE_SPACING: sample_spacing_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Frame state, advanced once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q   <= 1'b1;
			receiving_q    <= 1'b0;
			tick_left_q    <= 16'd0;
			bit_position_q <= 4'd0;
			shift_value_q  <= 8'd0;
		end else if (step) begin
			last_level_q   <= rx_level;
			receiving_q    <= receiving_d;
			tick_left_q    <= tick_left_d;
			bit_position_q <= bit_position_d;
			shift_value_q  <= shift_value_d;
		end
	end

endmodule

// ===== hw/rtl/uartrx_out_reg.sv =====
// Result register that holds one result beat until the consumer takes it.
module uartrx_out_reg (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  uartrx_pkg::result_t load_data,
	output logic                can_load,
	output logic                out_valid,
	input  logic                out_ready,
	output uartrx_pkg::result_t out_data
);
	import uartrx_pkg::*;

	logic    valid_q;
	result_t data_q;

	// A new beat may enter when the register is empty or is drained this cycle.
	assign can_load  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (can_load) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && can_load) begin
			data_q <= load_data;
		end
	end

endmodule

// ===== hw/rtl/uart_byte_receiver_filtered_unit.sv =====
// Filtered 8N1 UART byte receiver: one line sample in, one status/byte result out.
// Each input beat is one tick of an oversampling timebase carrying the receive line
// level, and each beat yields exactly one result beat in the following cycle (status 0 on
// ticks that end no frame). A beat is accepted every cycle while the result register
// is empty or being drained, so the sustained rate is one tick per clock; the frame
// state update and the result register are the only timing path. Registers start_wait
// (index 0) and sample_spacing (index 1) are written through the configuration channel,
// which is always ready; a value of zero behaves as one.
module uart_byte_receiver_filtered_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [uartrx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uartrx_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              rx_level,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [7:0]                        rx_byte
);
	import uartrx_pkg::*;

	cfg_wr_t cfg;
	result_t tick_result;
	result_t out_data;
	logic    step;

	// Configuration beats are taken at once.
	assign cfg_ready = 1'b1;
	assign cfg.wr    = cfg_valid;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	assign step = in_valid && in_ready;

	uartrx_frame u_frame (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.step     (step),
		.rx_level (rx_level),
		.result   (tick_result)
	);

	uartrx_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_valid),
		.load_data (tick_result),
		.can_load  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign status  = out_data.status;
	assign rx_byte = out_data.rx_byte;

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the filtered UART byte receiver: line ticks in, status beats out.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import uartrx_pkg::*;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 200;

	typedef enum {MODE_FLAT, MODE_SEND_IDLE, MODE_RECV_STALL, MODE_BOTH_IDLE} idle_mode_e;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	logic                  rx_level  = 1'b1;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [1:0]            status;
	logic [7:0]            rx_byte;

	uart_byte_receiver_filtered_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.rx_level  (rx_level),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.rx_byte   (rx_byte)
	);

	always #10 clk = ~clk;

	// Line levels waiting to be driven, and the results they are predicted to produce.
	logic    tick_q[$];
	result_t rx_results_q[$];

	int cycle_cnt    = 0;
	int mismatch_cnt = 0;
	int send_pct     = 0;
	int recv_pct     = 0;
	int hold_req     = 0;
	int hold_seen    = 0;
	int hold_left    = 0;

	// Receiver state as seen by the predictor.
	logic [15:0] wait_reg;
	logic [15:0] spacing_reg;
	logic        line_prev;
	logic        rcv_busy;
	logic [15:0] ticks_left;
	logic [3:0]  bit_pos;
	logic [7:0]  shift_reg;

	// Advance the receiver by one line tick and return the status beat it yields.
	function automatic result_t uart_tick(input logic level);
		result_t r;
		r.status  = STATUS_NONE;
		r.rx_byte = ZERO_BYTE;
		if (!rcv_busy) begin
			if (line_prev && !level) begin
				rcv_busy   = 1'b1;
				ticks_left = wait_reg;
				bit_pos    = 4'd0;
				shift_reg  = ZERO_BYTE;
			end
		end else if (ticks_left > 16'd1) begin
			ticks_left = ticks_left - 16'd1;
		end else if (bit_pos < DATA_BITS) begin
			shift_reg[bit_pos[2:0]] = level;
			bit_pos    = bit_pos + 4'd1;
			ticks_left = spacing_reg;
		end else begin
			// Stop check: the frame ends here and no start edge is looked for.
			r.rx_byte = shift_reg;
			if (!level)
				r.status = STATUS_FRAMING;
			else if (shift_reg == ZERO_BYTE || shift_reg == FILTER_BYTE)
				r.status = STATUS_FILTERED;
			else
				r.status = STATUS_ACCEPTED;
			rcv_busy   = 1'b0;
			ticks_left = 16'd0;
			bit_pos    = 4'd0;
		end
		line_prev = level;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		mismatch_cnt++;
		$display("ERROR cycle %0d: %s got 0x%0h expected 0x%0h", cycle_cnt, what, got, want);
	endtask

	// Input driver: predict on each accepted beat, then present the next level.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_level <= 1'b1;
		end else begin
			if (in_valid && in_ready)
				rx_results_q.push_back(uart_tick(rx_level));
			if (!in_valid || in_ready) begin
				if (tick_q.size() != 0 && $urandom_range(99) >= send_pct) begin
					in_valid <= 1'b1;
					rx_level <= tick_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each accepted beat against the oldest prediction.
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (rx_results_q.size() == 0) begin
					report_mismatch("unexpected result, status", {6'd0, status}, 8'd0);
				end else begin
					want = rx_results_q.pop_front();
					if (status !== want.status)
						report_mismatch("status", {6'd0, status}, {6'd0, want.status});
					if (rx_byte !== want.rx_byte)
						report_mismatch("rx_byte", rx_byte, want.rx_byte);
				end
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_pct);
		end
	end

	// Long receiver hold-off, started whenever the stimulus bumps hold_req.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 0;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	task automatic set_mode(input idle_mode_e m);
		case (m)
			MODE_FLAT: begin
				send_pct = 0;
				recv_pct = 0;
			end
			MODE_SEND_IDLE: begin
				send_pct = 77;
				recv_pct = 0;
			end
			MODE_RECV_STALL: begin
				send_pct = 0;
				recv_pct = 77;
			end
			default: begin
				send_pct = 12;
				recv_pct = 12;
			end
		endcase
	endtask

	// Register write beat; the predictor takes the new value once it is accepted.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		if (idx == CFG_START_WAIT)
			wait_reg = val;
		else
			spacing_reg = val;
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Wait until every queued level is driven and every predicted result has arrived.
	task automatic drain();
		do @(negedge clk); while (tick_q.size() != 0 || in_valid || rx_results_q.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	// One 8N1 frame timed to the current register values, then some idle-high ticks.
	task automatic push_frame(input logic [7:0] data, input logic stop, input int gap);
		int w;
		int s;
		w = (wait_reg == 16'd0) ? 1 : int'(wait_reg);
		s = (spacing_reg == 16'd0) ? 1 : int'(spacing_reg);
		tick_q.push_back(1'b1);
		repeat (w) tick_q.push_back(1'b0);
		for (int b = 0; b < 8; b++)
			repeat (s) tick_q.push_back(data[b]);
		tick_q.push_back(stop);
		repeat (gap) tick_q.push_back(1'b1);
	endtask

	task automatic push_levels(input int n, input logic level);
		repeat (n) tick_q.push_back(level);
	endtask

	task automatic push_noise(input int n);
		repeat (n) tick_q.push_back(1'($urandom_range(1)));
	endtask

	function automatic logic [7:0] rand_byte();
		case ($urandom_range(7))
			0: return ZERO_BYTE;
			1: return FILTER_BYTE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly clean frames with random content, with some line noise and cut-off frames.
	task automatic fill_random(input int n_ticks);
		int base;
		int pick;
		base = tick_q.size();
		while (tick_q.size() - base < n_ticks) begin
			pick = $urandom_range(99);
			if (pick < 78) begin
				push_frame(rand_byte(), ($urandom_range(9) != 0), $urandom_range(0, 2));
			end else if (pick < 90) begin
				push_noise($urandom_range(1, 8));
			end else begin
				push_levels(1, 1'b1);
				push_levels($urandom_range(1, 3), 1'b0);
				push_noise($urandom_range(1, 6));
			end
		end
	endtask

	// Stimulus sequence.
	initial begin
		wait_reg    = START_WAIT_RESET;
		spacing_reg = SAMPLE_SPACING_RESET;
		line_prev   = 1'b1;
		rcv_busy    = 1'b0;
		ticks_left  = 16'd0;
		bit_pos     = 4'd0;
		shift_reg   = ZERO_BYTE;
		set_mode(MODE_FLAT);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Start a frame at the reset timing and leave it in flight.
		push_levels(2, 1'b1);
		push_levels(1, 1'b0);
		push_noise(6);
		drain();

		// Zero registers behave as one; the frame in flight reloads with the new spacing.
		write_reg(CFG_START_WAIT, 16'd0);
		write_reg(CFG_SAMPLE_SPACING, 16'd0);
		push_levels(110, 1'b1);
		push_frame(ZERO_BYTE, 1'b1, 0);
		push_frame(FILTER_BYTE, 1'b1, 0);
		// Framing error whose stop tick is a falling edge, then the line held low.
		push_frame(8'hA5, 1'b0, 0);
		push_levels(3, 1'b0);
		push_frame(8'h3C, 1'b1, 0);
		push_frame(8'hFF, 1'b1, 1);
		drain();

		// Largest register values, written only with no frame in progress.
		while (rcv_busy) begin
			push_levels(12, 1'b1);
			drain();
		end
		write_reg(CFG_START_WAIT, 16'hFFFF);
		write_reg(CFG_SAMPLE_SPACING, 16'hFFFF);
		push_levels(8, 1'b1);
		drain();
		write_reg(CFG_START_WAIT, 16'd1);
		write_reg(CFG_SAMPLE_SPACING, 16'd1);
		fill_random(100);
		drain();

		// Random phases across idle patterns and register settings.
		for (int p = 0; p < 8; p++) begin
			set_mode(idle_mode_e'(p % 4));
			if (p == 5) begin
				write_reg(CFG_START_WAIT, 16'd24);
				write_reg(CFG_SAMPLE_SPACING, 16'd9);
			end else begin
				write_reg(CFG_START_WAIT, 16'($urandom_range(0, 6)));
				write_reg(CFG_SAMPLE_SPACING, 16'($urandom_range(0, 3)));
			end
			fill_random(p == 5 ? 160 : 50);
			drain();
		end

		// Back pressure: long receiver hold-off while the sender keeps offering beats,
		// then a sender pause until every result is in before the rest.
		set_mode(MODE_FLAT);
		write_reg(CFG_START_WAIT, 16'd3);
		write_reg(CFG_SAMPLE_SPACING, 16'd2);
		hold_req = hold_req + 1;
		fill_random(100);
		drain();
		fill_random(100);
		drain();

		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/uartrx_pkg.sv
hw/rtl/uartrx_frame.sv
hw/rtl/uartrx_out_reg.sv
hw/rtl/uart_byte_receiver_filtered_unit.sv
sim/tb_top.sv
